### rtl/bpv_pkg.sv
// ----------------------------------------------------------------------------
// bpv_pkg
// Types, sizes and codes shared by the bond persistence vote unit.
// ----------------------------------------------------------------------------
package bpv_pkg;

	localparam int NUM_ATOMS    = 1024;
	localparam int MAX_PARTNERS = 8;

	localparam int ATOM_W  = 10;
	localparam int TAG_W   = 32;
	localparam int SEEN_W  = 8;
	localparam int FRAC_W  = 16;
	localparam int THR_W   = SEEN_W + FRAC_W;
	localparam int APB_AW  = 4;

	localparam int CNT_AW   = (NUM_ATOMS > 1) ? $clog2(NUM_ATOMS) : 1;
	localparam int SLOT_W   = (MAX_PARTNERS > 1) ? $clog2(MAX_PARTNERS) : 1;
	localparam int CNT_W    = $clog2(MAX_PARTNERS + 1);
	localparam int ST_AW    = CNT_AW + SLOT_W;
	localparam int ST_DEPTH = 1 << ST_AW;
	localparam int ENTRY_W  = TAG_W + SEEN_W;

	localparam logic [SEEN_W-1:0] SEEN_MAX = {SEEN_W{1'b1}};

	localparam logic [1:0] REG_FRAME  = 2'd0;
	localparam logic [1:0] REG_CUTOFF = 2'd1;
	localparam logic [1:0] REG_NEWTON = 2'd2;

	typedef enum logic {
		OP_OBSERVE  = 1'b0,
		OP_FINALIZE = 1'b1
	} op_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_COUNT,
		ST_READ,
		ST_TEST
	} state_t;

	typedef struct packed {
		op_t               operation;
		logic [ATOM_W-1:0] atom_index;
		logic [TAG_W-1:0]  partner_tag;
		logic [TAG_W-1:0]  own_tag;
	} item_t;

	typedef struct packed {
		logic [ATOM_W-1:0] out_atom;
		logic [TAG_W-1:0]  bond_partner;
		logic              bond_valid;
		logic              overflow;
		logic              last;
	} result_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [SEEN_W-1:0] seen;
	} entry_t;

	typedef struct packed {
		logic [SEEN_W-1:0] frame_count;
		logic [FRAC_W-1:0] cutoff_fraction;
		logic              newton_mode;
		logic [THR_W-1:0]  threshold;
	} cfg_t;

	typedef struct packed {
		logic              hit;
		logic              keep;
		logic [SEEN_W-1:0] seen_next;
	} test_t;

endpackage

### rtl/bpv_ram.sv
// ----------------------------------------------------------------------------
// bpv_ram
// Generic single-port RAM with registered read data (read before write).
// ----------------------------------------------------------------------------
module bpv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata <= mem[addr];
		end
	end

endmodule

### rtl/bpv_regs.sv
// ----------------------------------------------------------------------------
// bpv_regs
// APB configuration registers and the registered persistence threshold.
// ----------------------------------------------------------------------------
module bpv_regs (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [bpv_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	output bpv_pkg::cfg_t         cfg
);
	import bpv_pkg::*;

	logic [SEEN_W-1:0] frame_q;
	logic [FRAC_W-1:0] cutoff_q;
	logic              newton_q;
	logic [THR_W-1:0]  thresh_q;
	logic              wr_en;
	logic [1:0]        reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q  <= SEEN_W'(1);
			cutoff_q <= FRAC_W'(32768);
			newton_q <= 1'b0;
			thresh_q <= THR_W'(32768);
		end else begin
			if (wr_en) begin
				case (reg_sel)
					REG_FRAME:  frame_q  <= pwdata[SEEN_W-1:0];
					REG_CUTOFF: cutoff_q <= pwdata[FRAC_W-1:0];
					REG_NEWTON: newton_q <= pwdata[0];
					default: ;
				endcase
			end
			// track the product of the registers in the cycle after they change
			thresh_q <= THR_W'(cutoff_q * frame_q);
		end
	end

	always_comb begin
		case (reg_sel)
			REG_FRAME:  prdata = 32'(frame_q);
			REG_CUTOFF: prdata = 32'(cutoff_q);
			REG_NEWTON: prdata = 32'(newton_q);
			default:    prdata = '0;
		endcase
	end

	assign cfg = '{frame_count: frame_q, cutoff_fraction: cutoff_q,
		newton_mode: newton_q, threshold: thresh_q};

endmodule

### rtl/bpv_test.sv
// ----------------------------------------------------------------------------
// bpv_test
// Shared entry test: tag match with saturating count, and persistence keep.
// ----------------------------------------------------------------------------
module bpv_test (
	input  bpv_pkg::entry_t               entry,
	input  logic [bpv_pkg::TAG_W-1:0]     partner_tag,
	input  logic [bpv_pkg::TAG_W-1:0]     own_tag,
	input  logic                          newton_mode,
	input  logic [bpv_pkg::THR_W-1:0]     threshold,
	output bpv_pkg::test_t                test
);
	import bpv_pkg::*;

	logic [THR_W-1:0] score;
	logic             below_own;

	assign score     = {entry.seen, {FRAC_W{1'b0}}};
	assign below_own = newton_mode && (own_tag > entry.tag);

	assign test.hit       = (entry.tag == partner_tag);
	assign test.keep      = (score > threshold) && !below_own;
	assign test.seen_next = (entry.seen == SEEN_MAX) ? entry.seen
		: entry.seen + SEEN_W'(1);

endmodule

### rtl/bond_persistence_vote_unit.sv
// ----------------------------------------------------------------------------
// bond_persistence_vote_unit
// Per-atom bond partner table with persistence vote over history frames.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken on item when start is high and busy is low. An observe
//   word counts up or appends one partner tag in the atom's table (or flags
//   overflow when full); a finalize word walks the table in insertion order,
//   emits each persistent partner on result, and empties the table.
//   Each result word is on result for one cycle, marked by result_strobe;
//   result.last marks the final word of an item. The receiver cannot stall,
//   so results are never held.
//   Walk: stored partners are read and tested one at a time through the
//   single store RAM port and the shared entry test. Busy stays high while
//   the fill count is read and the partners (at most 8) are walked; an
//   observe match ends the walk. A finalize's last word appears in the
//   cycle that busy falls. Out-of-range items start no walk; a finalize
//   among them gives one last word. Reset: registers take their defaults
//   and a clearing pass zeroes each fill count, one atom per cycle over
//   NUM_ATOMS (1024) atoms, busy high. APB writes are taken at any time.
// ----------------------------------------------------------------------------
module bond_persistence_vote_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  bpv_pkg::item_t             item,
	output logic                       result_strobe,
	output bpv_pkg::result_t           result,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [bpv_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import bpv_pkg::*;

	cfg_t   cfg;
	test_t  test;
	entry_t entry;

	state_t state_q, state_d;
	item_t  item_q, item_d;
	logic [CNT_W-1:0]  n_q, n_d, slot_q, slot_d;
	logic [CNT_AW-1:0] clr_q, clr_d;
	logic              pend_valid_q, pend_valid_d;
	logic [TAG_W-1:0]  pend_tag_q, pend_tag_d;
	result_t           result_q, result_d;
	logic              strobe_q, strobe_d;

	logic              cnt_en, cnt_we;
	logic [CNT_AW-1:0] cnt_addr;
	logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;
	logic              st_en, st_we;
	logic [ST_AW-1:0]  st_addr;
	entry_t            st_wdata;
	logic [ENTRY_W-1:0] st_rdata;
	logic              in_range;

	bpv_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bpv_ram #(.WIDTH(CNT_W), .DEPTH(NUM_ATOMS)) u_cnt_ram (
		.clk   (clk),
		.en    (cnt_en),
		.we    (cnt_we),
		.addr  (cnt_addr),
		.wdata (cnt_wdata),
		.rdata (cnt_rdata)
	);

	bpv_ram #(.WIDTH(ENTRY_W), .DEPTH(ST_DEPTH)) u_store_ram (
		.clk   (clk),
		.en    (st_en),
		.we    (st_we),
		.addr  (st_addr),
		.wdata (st_wdata),
		.rdata (st_rdata)
	);

	assign entry = entry_t'(st_rdata);

	bpv_test u_test (
		.entry       (entry),
		.partner_tag (item_q.partner_tag),
		.own_tag     (item_q.own_tag),
		.newton_mode (cfg.newton_mode),
		.threshold   (cfg.threshold),
		.test        (test)
	);

	assign in_range = 32'(item.atom_index) < NUM_ATOMS;
	assign busy     = (state_q != ST_IDLE);

	always_comb begin
		state_d      = state_q;
		item_d       = item_q;
		n_d          = n_q;
		slot_d       = slot_q;
		clr_d        = clr_q;
		pend_valid_d = pend_valid_q;
		pend_tag_d   = pend_tag_q;
		result_d     = result_q;
		strobe_d     = 1'b0;
		cnt_en       = 1'b0;
		cnt_we       = 1'b0;
		cnt_addr     = CNT_AW'(item_q.atom_index);
		cnt_wdata    = '0;
		st_en        = 1'b0;
		st_we        = 1'b0;
		st_addr      = {CNT_AW'(item_q.atom_index), SLOT_W'(slot_q)};
		st_wdata     = '{tag: item_q.partner_tag, seen: SEEN_W'(1)};

		case (state_q)
			ST_CLEAR: begin
				cnt_en   = 1'b1;
				cnt_we   = 1'b1;
				cnt_addr = clr_q;
				if (clr_q == CNT_AW'(NUM_ATOMS - 1)) begin
					state_d = ST_IDLE;
				end else begin
					clr_d = clr_q + CNT_AW'(1);
				end
			end
			ST_IDLE: begin
				if (start) begin
					item_d       = item;
					pend_valid_d = 1'b0;
					if (in_range) begin
						cnt_en   = 1'b1;
						cnt_addr = CNT_AW'(item.atom_index);
						state_d  = ST_COUNT;
					end else if (item.operation == OP_FINALIZE) begin
						strobe_d = 1'b1;
						result_d = '{out_atom: item.atom_index, bond_partner: '0,
							bond_valid: 1'b0, overflow: 1'b0, last: 1'b1};
					end
				end
			end
			ST_COUNT: begin
				n_d     = cnt_rdata;
				slot_d  = '0;
				state_d = ST_READ;
			end
			ST_READ: begin
				if (slot_q < n_q) begin
					st_en   = 1'b1;
					state_d = ST_TEST;
				end else begin
					state_d = ST_IDLE;
					if (item_q.operation == OP_OBSERVE) begin
						if (n_q >= CNT_W'(MAX_PARTNERS)) begin
							strobe_d = 1'b1;
							result_d = '{out_atom: item_q.atom_index,
								bond_partner: item_q.partner_tag, bond_valid: 1'b0,
								overflow: 1'b1, last: 1'b1};
						end else begin
							// append at the first free slot
							st_en     = 1'b1;
							st_we     = 1'b1;
							cnt_en    = 1'b1;
							cnt_we    = 1'b1;
							cnt_wdata = n_q + CNT_W'(1);
						end
					end else begin
						cnt_en   = 1'b1;
						cnt_we   = 1'b1;
						strobe_d = 1'b1;
						result_d = '{out_atom: item_q.atom_index,
							bond_partner: pend_valid_q ? pend_tag_q : '0,
							bond_valid: pend_valid_q, overflow: 1'b0, last: 1'b1};
					end
				end
			end
			ST_TEST: begin
				if (item_q.operation == OP_OBSERVE) begin
					if (test.hit) begin
						st_en    = 1'b1;
						st_we    = 1'b1;
						st_wdata = '{tag: entry.tag, seen: test.seen_next};
						state_d  = ST_IDLE;
					end else begin
						slot_d  = slot_q + CNT_W'(1);
						state_d = ST_READ;
					end
				end else begin
					// hold one kept partner back so the final word can carry last
					if (test.keep) begin
						if (pend_valid_q) begin
							strobe_d = 1'b1;
							result_d = '{out_atom: item_q.atom_index,
								bond_partner: pend_tag_q, bond_valid: 1'b1,
								overflow: 1'b0, last: 1'b0};
						end
						pend_valid_d = 1'b1;
						pend_tag_d   = entry.tag;
					end
					slot_d  = slot_q + CNT_W'(1);
					state_d = ST_READ;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			strobe_q     <= 1'b0;
			pend_valid_q <= 1'b0;
		end else begin
			state_q      <= state_d;
			clr_q        <= clr_d;
			strobe_q     <= strobe_d;
			pend_valid_q <= pend_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		item_q     <= item_d;
		n_q        <= n_d;
		slot_q     <= slot_d;
		pend_tag_q <= pend_tag_d;
		result_q   <= result_d;
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

`ifndef SYNTHESIS
	a_no_result_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CLEAR |-> !result_strobe)
		else $error("result word during clearing pass");

	a_range_item_walks: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && in_range |=> state_q == ST_COUNT)
		else $error("in-range item did not start a table walk");

	a_more_words_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && !result.last |-> busy)
		else $error("non-final word while the walk has ended");

	a_fill_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_READ |-> n_q <= CNT_W'(MAX_PARTNERS))
		else $error("fill count beyond table size");
`endif

endmodule
